/* src/bmrd_pkg.sv */
// ----------------------------------------------------------------------------
// bmrd_pkg
// Shared widths, register indexes and the configuration bundle of the block
// mean and rms decimator.
// ----------------------------------------------------------------------------
`default_nettype none

package bmrd_pkg;

  localparam int BLOCK_W     = 11;
  localparam int DELTA_W     = 21;
  localparam int TICK_W      = 64;
  localparam int OUT_W       = 16;
  localparam int CFG_INDEX_W = 4;
  localparam int CFG_DATA_W  = 32;
  localparam int PROD_W      = BLOCK_W + DELTA_W;

  // register indexes of the configuration port
  localparam logic [CFG_INDEX_W-1:0] CFG_BLOCK_SIZE  = CFG_INDEX_W'(0);
  localparam logic [CFG_INDEX_W-1:0] CFG_DELTA_TICKS = CFG_INDEX_W'(1);

  // effective configuration seen by the front end
  typedef struct packed {
    logic [BLOCK_W-1:0] n;
    logic [DELTA_W-1:0] delta;
    logic               clear;
  } cfg_t;

endpackage

`default_nettype wire

/* src/bmrd_queue.sv */
// ----------------------------------------------------------------------------
// bmrd_queue
// Two-entry queue carrying finished block sums from the front end to the
// arithmetic back end.
// ----------------------------------------------------------------------------
`default_nettype none

module bmrd_queue #(
  parameter int WIDTH = 8
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push_valid,
  output logic             push_ready,
  input  logic [WIDTH-1:0] push_data,
  output logic             pop_valid,
  input  logic             pop_ready,
  output logic [WIDTH-1:0] pop_data
);

  logic [WIDTH-1:0] entries [2];
  logic             wr_ptr;
  logic             rd_ptr;
  logic [1:0]       count;
  logic             do_push;
  logic             do_pop;

  assign push_ready = (count != 2'd2);
  assign pop_valid  = (count != 2'd0);
  assign pop_data   = entries[rd_ptr];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  // pointers and occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (do_push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (do_pop) begin
        rd_ptr <= ~rd_ptr;
      end
      if (do_push && !do_pop) begin
        count <= count + 2'd1;
      end else if (do_pop && !do_push) begin
        count <= count - 2'd1;
      end
    end
  end

  // entry storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= push_data;
    end
  end

endmodule

`default_nettype wire

/* src/bmrd_front.sv */
// ----------------------------------------------------------------------------
// bmrd_front
// Takes samples, detects tick gaps, squares and accumulates over a block and
// hands each completed block to the queue.
// ----------------------------------------------------------------------------
`default_nettype none

module bmrd_front #(
  parameter int SAMPLE_WIDTH = 16,
  parameter int CNT_W        = 11,
  parameter int SUM_W        = 27,
  parameter int SQ_W         = 42,
  parameter int ENTRY_W      = 8
) (
  input  logic                             clk,
  input  logic                             rst,
  input  bmrd_pkg::cfg_t                   cfg,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic signed [SAMPLE_WIDTH-1:0]   sample,
  input  logic signed [bmrd_pkg::TICK_W-1:0] tick,
  output logic                             push_valid,
  input  logic                             push_ready,
  output logic [ENTRY_W-1:0]               push_data
);

  import bmrd_pkg::*;

  // input stage
  logic                           s1_valid;
  logic signed [SAMPLE_WIDTH-1:0] s1_sample;
  logic [2*SAMPLE_WIDTH-1:0]      s1_sq;
  logic [TICK_W-1:0]              s1_tick;
  logic                           s1_gap;
  logic                           s1_fire;
  logic                           in_fire;
  logic signed [2*SAMPLE_WIDTH-1:0] square;

  // gap tracking
  logic              seen_any;
  logic [TICK_W-1:0] expected_tick;

  // accumulators
  logic [CNT_W-1:0]        fill_count;
  logic signed [SUM_W-1:0] running_sum;
  logic [SQ_W-1:0]         running_square_sum;
  logic [TICK_W-1:0]       block_start_tick;

  logic                    restart;
  logic [CNT_W-1:0]        fill_next;
  logic signed [SUM_W-1:0] sum_next;
  logic [SQ_W-1:0]         square_sum_next;
  logic [TICK_W-1:0]       start_next;
  logic                    block_done;

  assign in_fire = in_valid && in_ready;
  assign square  = (2*SAMPLE_WIDTH)'(sample) * (2*SAMPLE_WIDTH)'(sample);

  // accumulate the staged sample
  always_comb begin
    restart         = s1_gap || (fill_count == '0);
    fill_next       = restart ? CNT_W'(1) : fill_count + CNT_W'(1);
    sum_next        = (restart ? '0 : running_sum) + SUM_W'(s1_sample);
    square_sum_next = (restart ? '0 : running_square_sum) + SQ_W'(s1_sq);
    start_next      = restart ? s1_tick : block_start_tick;
    block_done      = (BLOCK_W'(fill_next) == cfg.n);
  end

  assign s1_fire    = s1_valid && (!block_done || push_ready);
  assign in_ready   = !s1_valid || s1_fire;
  assign push_valid = s1_valid && block_done;
  assign push_data  = {sum_next, square_sum_next, cfg.n, cfg.delta, start_next};

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid      <= 1'b0;
      seen_any      <= 1'b0;
      expected_tick <= '0;
      fill_count    <= '0;
    end else begin
      if (in_fire) begin
        s1_valid <= 1'b1;
      end else if (s1_fire) begin
        s1_valid <= 1'b0;
      end
      if (in_fire) begin
        seen_any      <= 1'b1;
        expected_tick <= $unsigned(tick) + TICK_W'(cfg.delta);
      end
      if (s1_fire) begin
        fill_count <= block_done ? '0 : fill_next;
      end
      // register write drops the partial block
      if (cfg.clear) begin
        seen_any   <= 1'b0;
        fill_count <= '0;
      end
    end
  end

  // staged sample and accumulator payload
  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_sample <= sample;
      s1_sq     <= $unsigned(square);
      s1_tick   <= $unsigned(tick);
      s1_gap    <= !seen_any || ($unsigned(tick) != expected_tick);
    end
    if (s1_fire) begin
      running_sum        <= sum_next;
      running_square_sum <= square_sum_next;
      block_start_tick   <= start_next;
    end
  end

endmodule

`default_nettype wire

/* src/bmrd_back.sv */
// ----------------------------------------------------------------------------
// bmrd_back
// Per-block arithmetic: two restoring dividers by the block size, a
// digit-by-digit square root, the last tick and the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module bmrd_back #(
  parameter int SUM_W   = 27,
  parameter int SQ_W    = 42,
  parameter int ENTRY_W = 8
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               pop_valid,
  output logic                               pop_ready,
  input  logic [ENTRY_W-1:0]                 pop_data,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic signed [bmrd_pkg::OUT_W-1:0]  mean,
  output logic [bmrd_pkg::OUT_W-1:0]         rms,
  output logic signed [bmrd_pkg::TICK_W-1:0] first_tick,
  output logic signed [bmrd_pkg::TICK_W-1:0] last_tick
);

  import bmrd_pkg::*;

  localparam int RT_STEPS = (SQ_W + 1) / 2;
  localparam int RW       = 2 * RT_STEPS;
  localparam int STEP_W   = $clog2(SQ_W);

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_DIV  = 3'd1;
  localparam logic [2:0] ST_ROOT = 3'd2;
  localparam logic [2:0] ST_MUL  = 3'd3;
  localparam logic [2:0] ST_DONE = 3'd4;

  logic [2:0] state;

  // unpacked queue entry
  logic signed [SUM_W-1:0] e_sum;
  logic [SQ_W-1:0]         e_sq;
  logic [BLOCK_W-1:0]      e_n;
  logic [DELTA_W-1:0]      e_delta;
  logic [TICK_W-1:0]       e_first;
  logic [SUM_W-1:0]        e_mag;

  // working registers
  logic                neg;
  logic [BLOCK_W-1:0]  n_r;
  logic [DELTA_W-1:0]  delta_r;
  logic [TICK_W-1:0]   first_r;
  logic [SQ_W-1:0]     qa;
  logic [SQ_W-1:0]     qb;
  logic [BLOCK_W-1:0]  ra;
  logic [BLOCK_W-1:0]  rb;
  logic [STEP_W-1:0]   step;
  logic [RW-1:0]       x;
  logic [RW-1:0]       res;
  logic [RW-1:0]       bitv;
  logic [PROD_W-1:0]   prod;

  // step results
  logic [BLOCK_W:0]   ta;
  logic [BLOCK_W:0]   tb;
  logic               ge_a;
  logic               ge_b;
  logic [BLOCK_W-1:0] ra_next;
  logic [BLOCK_W-1:0] rb_next;
  logic [RW:0]        trial;
  logic               ge_r;
  logic [RW-1:0]      x_next;
  logic [RW-1:0]      res_next;
  logic               out_free;

  assign {e_sum, e_sq, e_n, e_delta, e_first} = pop_data;
  assign e_mag     = e_sum[SUM_W-1] ? $unsigned(-e_sum) : $unsigned(e_sum);
  assign pop_ready = (state == ST_IDLE);
  assign out_free  = !out_valid || out_ready;

  // one restoring division step for each dividend
  always_comb begin
    ta      = {ra, qa[SQ_W-1]};
    tb      = {rb, qb[SQ_W-1]};
    ge_a    = (ta >= {1'b0, n_r});
    ge_b    = (tb >= {1'b0, n_r});
    ra_next = ge_a ? BLOCK_W'(ta - {1'b0, n_r}) : ta[BLOCK_W-1:0];
    rb_next = ge_b ? BLOCK_W'(tb - {1'b0, n_r}) : tb[BLOCK_W-1:0];
  end

  // one square root step
  always_comb begin
    trial    = (RW+1)'(res) + (RW+1)'(bitv);
    ge_r     = ((RW+1)'(x) >= trial);
    x_next   = ge_r ? RW'((RW+1)'(x) - trial) : x;
    res_next = ge_r ? (res >> 1) + bitv : (res >> 1);
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      step      <= '0;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (pop_valid) begin
            state <= ST_DIV;
            step  <= '0;
          end
        end
        ST_DIV: begin
          if (step == STEP_W'(SQ_W - 1)) begin
            state <= ST_ROOT;
            step  <= '0;
          end else begin
            step <= step + STEP_W'(1);
          end
        end
        ST_ROOT: begin
          if (step == STEP_W'(RT_STEPS - 1)) begin
            state <= ST_MUL;
          end else begin
            step <= step + STEP_W'(1);
          end
        end
        ST_MUL: begin
          state <= ST_DONE;
        end
        ST_DONE: begin
          if (out_free) begin
            out_valid <= 1'b1;
            state     <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    unique case (state)
      ST_IDLE: begin
        if (pop_valid) begin
          neg     <= e_sum[SUM_W-1];
          n_r     <= e_n;
          delta_r <= e_delta;
          first_r <= e_first;
          qa      <= SQ_W'(e_mag);
          qb      <= e_sq;
          ra      <= '0;
          rb      <= '0;
        end
      end
      ST_DIV: begin
        qa <= {qa[SQ_W-2:0], ge_a};
        qb <= {qb[SQ_W-2:0], ge_b};
        ra <= ra_next;
        rb <= rb_next;
        if (step == STEP_W'(SQ_W - 1)) begin
          x    <= RW'({qb[SQ_W-2:0], ge_b});
          res  <= '0;
          bitv <= RW'(1) << (RW - 2);
        end
      end
      ST_ROOT: begin
        x    <= x_next;
        res  <= res_next;
        bitv <= bitv >> 2;
      end
      ST_MUL: begin
        prod <= PROD_W'(delta_r) * PROD_W'(n_r);
      end
      ST_DONE: begin
        if (out_free) begin
          mean       <= neg ? -$signed(qa[OUT_W-1:0]) : $signed(qa[OUT_W-1:0]);
          rms        <= res[OUT_W-1:0];
          first_tick <= $signed(first_r);
          last_tick  <= $signed(first_r + TICK_W'(prod) - TICK_W'(1));
        end
      end
      default: begin
      end
    endcase
  end

endmodule

`default_nettype wire

/* src/block_mean_rms_decimator_top.sv */
// ----------------------------------------------------------------------------
// block_mean_rms_decimator_top
// Block mean and rms decimator: sums samples and squares over blocks and
// reports mean, rms and the tick span of every completed block.
// ----------------------------------------------------------------------------
// Usage:
//   in channel (in_valid/in_ready, sample, tick) takes one sample request per
//   cycle while the queue has room. A tick that is not the previous tick plus
//   delta_ticks drops the partial block and starts a new one with that sample.
//   out channel (out_valid/out_ready) delivers one result per block.
//   cfg channel (cfg_valid/cfg_ready, cfg_index, cfg_data) writes block_size
//   (index 0) and delta_ticks (index 1); either write drops any partial block.
//   The restoring dividers and the root sequencer work one bit a cycle. The
//   back end takes a new block only when its sequencer is idle; the two-entry
//   block queue holds finished blocks meanwhile.
//   Reset sets block_size and delta_ticks to 1 and empties all stages. A
//   stalled receiver holds the result in the output register; the back end
//   finishes its next block and waits, the queue fills, then input stalls.
// ----------------------------------------------------------------------------
`default_nettype none

module block_mean_rms_decimator_top #(
  parameter int SAMPLE_WIDTH = 16,
  parameter int MAX_BLOCK    = 1024
) (
  input  logic                                    clk,
  input  logic                                    rst,
  input  logic                                    cfg_valid,
  output logic                                    cfg_ready,
  input  logic [bmrd_pkg::CFG_INDEX_W-1:0]        cfg_index,
  input  logic [bmrd_pkg::CFG_DATA_W-1:0]         cfg_data,
  input  logic                                    in_valid,
  output logic                                    in_ready,
  input  logic signed [SAMPLE_WIDTH-1:0]          sample,
  input  logic signed [bmrd_pkg::TICK_W-1:0]      tick,
  output logic                                    out_valid,
  input  logic                                    out_ready,
  output logic signed [bmrd_pkg::OUT_W-1:0]       mean,
  output logic [bmrd_pkg::OUT_W-1:0]              rms,
  output logic signed [bmrd_pkg::TICK_W-1:0]      first_tick,
  output logic signed [bmrd_pkg::TICK_W-1:0]      last_tick
);

  import bmrd_pkg::*;

  localparam int REG_MAX = 2**BLOCK_W - 1;
  localparam int NMAX    = (MAX_BLOCK < REG_MAX) ? MAX_BLOCK : REG_MAX;
  localparam int LOG_N   = $clog2(NMAX);
  localparam int CNT_W   = $clog2(NMAX + 1);
  localparam int SUM_W   = SAMPLE_WIDTH + LOG_N + 1;
  localparam int SQ_W    = 2 * SAMPLE_WIDTH + LOG_N;
  localparam int ENTRY_W = SUM_W + SQ_W + BLOCK_W + DELTA_W + TICK_W;

  logic [BLOCK_W-1:0] block_size;
  logic [DELTA_W-1:0] delta_ticks;
  logic               cfg_fire;
  logic               cfg_known;
  cfg_t               cfg;

  logic               q_push_valid;
  logic               q_push_ready;
  logic [ENTRY_W-1:0] q_push_data;
  logic               q_pop_valid;
  logic               q_pop_ready;
  logic [ENTRY_W-1:0] q_pop_data;

  assign cfg_ready = 1'b1;
  assign cfg_fire  = cfg_valid && cfg_ready;
  assign cfg_known = (cfg_index == CFG_BLOCK_SIZE) || (cfg_index == CFG_DELTA_TICKS);

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      block_size  <= BLOCK_W'(1);
      delta_ticks <= DELTA_W'(1);
    end else begin
      if (cfg_fire) begin
        if (cfg_index == CFG_BLOCK_SIZE) begin
          block_size <= cfg_data[BLOCK_W-1:0];
        end
        if (cfg_index == CFG_DELTA_TICKS) begin
          delta_ticks <= cfg_data[DELTA_W-1:0];
        end
      end
    end
  end

  // effective block size: zero means one, clamp at the block limit
  always_comb begin
    priority if (block_size == '0) begin
      cfg.n = BLOCK_W'(1);
    end else if (32'(block_size) > 32'(MAX_BLOCK)) begin
      cfg.n = BLOCK_W'(NMAX);
    end else begin
      cfg.n = block_size;
    end
    cfg.delta = delta_ticks;
    // a known register write drops the partial block at the same edge
    cfg.clear = cfg_fire && cfg_known;
  end

  bmrd_front #(
    .SAMPLE_WIDTH (SAMPLE_WIDTH),
    .CNT_W        (CNT_W),
    .SUM_W        (SUM_W),
    .SQ_W         (SQ_W),
    .ENTRY_W      (ENTRY_W)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .sample     (sample),
    .tick       (tick),
    .push_valid (q_push_valid),
    .push_ready (q_push_ready),
    .push_data  (q_push_data)
  );

  bmrd_queue #(
    .WIDTH (ENTRY_W)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (q_push_valid),
    .push_ready (q_push_ready),
    .push_data  (q_push_data),
    .pop_valid  (q_pop_valid),
    .pop_ready  (q_pop_ready),
    .pop_data   (q_pop_data)
  );

  bmrd_back #(
    .SUM_W   (SUM_W),
    .SQ_W    (SQ_W),
    .ENTRY_W (ENTRY_W)
  ) u_back (
    .clk        (clk),
    .rst        (rst),
    .pop_valid  (q_pop_valid),
    .pop_ready  (q_pop_ready),
    .pop_data   (q_pop_data),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .mean       (mean),
    .rms        (rms),
    .first_tick (first_tick),
    .last_tick  (last_tick)
  );

endmodule

`default_nettype wire
